### design/akm_pkg.sv
// ----------------------------------------------------------------------------
// akm_pkg
// Shared types, constants and the slot hash of the attribute kind merge table.
// ----------------------------------------------------------------------------
`default_nettype none

package akm_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int ID_W    = 64;
    localparam int KIND_W  = 4;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [IDX_W:0]    t_cnt;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [ID_W-1:0]   t_id;

    localparam t_cnt ENTRIES_CNT = t_cnt'(ENTRIES);
    localparam t_idx LAST_IDX    = t_idx'(ENTRIES - 1);

    typedef enum logic {
        OP_STORE  = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CONFLICT = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef struct packed {
        t_op   op;
        t_id   type_id;
        t_id   name_id;
        t_kind value_kind;
    } t_req;

    typedef struct packed {
        t_kind   kind;
        t_status status;
    } t_res;

    typedef struct packed {
        t_kind any_code;
        t_kind none_code;
    } t_cfg;

    typedef struct packed {
        logic  valid;
        t_id   type_id;
        t_id   name_id;
        t_kind kind;
    } t_slot;

    typedef struct packed {
        logic  rd_en;
        t_idx  rd_addr;
        logic  wr_en;
        t_idx  wr_addr;
        t_slot wr_data;
    } t_mem_req;

    // xor fold of the 128-bit key, then one correction into 0..ENTRIES-1
    function automatic t_idx slot_hash(input t_id ty, input t_id nm);
        logic [2*ID_W-1:0] key;
        logic [IDX_W-1:0]  h;
        key = {ty, nm};
        h   = '0;
        for (int i = 0; i < 2 * ID_W; i++) begin
            h[i % IDX_W] = h[i % IDX_W] ^ key[i];
        end
        if ({1'b0, h} >= ENTRIES_CNT) begin
            h = h - ENTRIES_CNT[IDX_W-1:0];
        end
        return h;
    endfunction

endpackage

`default_nettype wire

### design/akm_mem.sv
// ----------------------------------------------------------------------------
// akm_mem
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module akm_mem
    import akm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_slot         o_rd_data
);

    t_slot r_mem [ENTRIES];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### design/akm_ctrl.sv
// ----------------------------------------------------------------------------
// akm_ctrl
// Probe sequencer: clears the memory after reset, hashes the key, walks the
// slots by linear probing; a store merges the kind and writes the slot back.
// ----------------------------------------------------------------------------
`default_nettype none

module akm_ctrl
    import akm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    input  wire t_req  i_req,
    input  wire t_cfg  i_cfg,
    output logic       o_res_valid,
    input  wire logic  i_res_ready,
    output t_res       o_res,
    output t_mem_req   o_mem,
    input  wire t_slot i_rd_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

    t_state r_state;
    t_idx   r_addr;
    t_cnt   r_probes;
    t_req   r_req;
    t_res   r_res;

    t_idx   n_addr;
    t_cnt   n_probes;
    t_res   n_res;
    logic   hit;
    logic   empty;
    logic   last_probe;

    assign n_addr     = (r_addr == LAST_IDX) ? '0 : r_addr + 1'b1;
    assign n_probes   = r_probes + 1'b1;
    assign hit        = i_rd_data.valid && (i_rd_data.type_id == r_req.type_id)
                        && (i_rd_data.name_id == r_req.name_id);
    assign empty      = !i_rd_data.valid;
    assign last_probe = (n_probes == ENTRIES_CNT);

    always_comb begin
        o_mem                    = '0;
        o_mem.rd_addr            = r_addr;
        o_mem.wr_addr            = r_addr;
        o_mem.wr_data.valid      = 1'b1;
        o_mem.wr_data.type_id    = r_req.type_id;
        o_mem.wr_data.name_id    = r_req.name_id;
        o_mem.wr_data.kind       = r_req.value_kind;
        n_res.kind               = '0;
        n_res.status             = ST_OK;
        case (r_state)
            S_CLEAR: begin
                o_mem.wr_en         = 1'b1;
                o_mem.wr_data.valid = 1'b0;
            end
            S_READ: begin
                o_mem.rd_en = 1'b1;
            end
            S_CHECK: begin
                if (r_req.op == OP_LOOKUP) begin
                    if (hit) begin
                        n_res.kind = i_rd_data.kind;
                    end else begin
                        n_res.kind = i_cfg.any_code;
                    end
                end else if (hit) begin
                    // equal or already any: leave the slot alone
                    if (i_rd_data.kind == r_req.value_kind
                            || i_rd_data.kind == i_cfg.any_code) begin
                        o_mem.wr_en = 1'b0;
                    end else if (i_rd_data.kind == i_cfg.none_code) begin
                        o_mem.wr_en = 1'b1;
                    end else begin
                        o_mem.wr_en        = 1'b1;
                        o_mem.wr_data.kind = i_cfg.any_code;
                        n_res.status       = ST_CONFLICT;
                    end
                end else if (empty) begin
                    o_mem.wr_en = 1'b1;
                end else if (last_probe) begin
                    n_res.status = ST_FULL;
                end
            end
            default: begin
                o_mem.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_probes <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_addr <= n_addr;
                    if (r_addr == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req    <= i_req;
                        r_addr   <= slot_hash(i_req.type_id, i_req.name_id);
                        r_probes <= '0;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (hit || empty || last_probe) begin
                        r_res   <= n_res;
                        r_state <= S_DONE;
                    end else begin
                        r_addr   <= n_addr;
                        r_probes <= n_probes;
                        r_state  <= S_READ;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    a_lookup_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && r_req.op == OP_LOOKUP |-> o_res.status == ST_OK)
        else $error("lookup item finished with nonzero status");

    a_store_kind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && r_req.op == OP_STORE |-> o_res.kind == '0)
        else $error("store item finished with nonzero kind");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_probes < ENTRIES_CNT)
        else $error("probe count ran past the table size");

    a_fill_only_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.wr_en && o_mem.wr_data.valid |-> r_state == S_CHECK && r_req.op == OP_STORE)
        else $error("slot written outside a store item");

    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK && n_res.status == ST_FULL |-> !o_mem.wr_en)
        else $error("dropped store wrote a slot");

endmodule

`default_nettype wire

### design/attribute_kind_merge_table.sv
// ----------------------------------------------------------------------------
// attribute_kind_merge_table
// Keyed table of observed value kinds for (type id, name id) pairs, with
// store-and-merge and lookup items and an APB register port for the kind codes.
// ----------------------------------------------------------------------------
// Each item reads and checks the key's home slot, then reads and checks each
// further slot in turn by linear probe over the slot memory, until it finds
// the key or an empty slot, or until all ENTRIES slots are probed when the
// table is full and the key is absent. Read data is registered in the memory.
// After reset a clearing pass that marks every slot empty runs
// through the memory, and input items are stalled until it ends; register
// writes are taken throughout. A finished result waits in an output register.
`default_nettype none

module attribute_kind_merge_table
    import akm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_opcode,
    input  wire logic [ID_W-1:0]   i_type_id,
    input  wire logic [ID_W-1:0]   i_name_id,
    input  wire logic [KIND_W-1:0] i_value_kind,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [KIND_W-1:0]      o_result_kind,
    output logic [1:0]             o_status,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam logic REG_ANY  = 1'b0;
    localparam logic REG_NONE = 1'b1;

    t_cfg     r_cfg;
    logic     r_out_valid;
    t_res     r_out;

    t_req     req;
    t_res     res;
    logic     res_valid;
    logic     out_free;
    logic     cfg_wr;
    t_mem_req mem_req;
    t_slot    rd_data;

    assign req.op         = t_op'(i_opcode);
    assign req.type_id    = i_type_id;
    assign req.name_id    = i_name_id;
    assign req.value_kind = i_value_kind;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.any_code  <= t_kind'(0);
            r_cfg.none_code <= t_kind'(1);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_ANY:  r_cfg.any_code  <= pwdata[KIND_W-1:0];
                REG_NONE: r_cfg.none_code <= pwdata[KIND_W-1:0];
                default:  r_cfg.any_code  <= r_cfg.any_code;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ANY:  prdata = {{(32-KIND_W){1'b0}}, r_cfg.any_code};
            REG_NONE: prdata = {{(32-KIND_W){1'b0}}, r_cfg.none_code};
            default:  prdata = '0;
        endcase
    end

    // output register frees itself when the item is taken
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && out_free) begin
            r_out_valid <= 1'b1;
            r_out       <= res;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out.kind;
    assign o_status      = r_out.status;

    akm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req       (req),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .i_res_ready (out_free),
        .o_res       (res),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data)
    );

    akm_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire

### tb/attribute_kind_merge_table_test.sv
// ----------------------------------------------------------------------------
// attribute_kind_merge_table_test
// Drives store and lookup items into the kind merge table under bursty input
// and random output stalls, across several any/none code settings written
// over the register port. A scoreboard keeps its own copy of the table, merges
// every accepted item into it and compares each result with the oldest
// prediction. Key reuse from a pool fills the table so that full-table drops
// and merges into a full table are exercised too.
// ----------------------------------------------------------------------------
module attribute_kind_merge_table_test
    import akm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_ANY_CODE  = 3'd0;
    localparam logic [2:0] ADDR_NONE_CODE = 3'd4;
    localparam int KEY_POOL     = 80;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 110;

    class kind_table_scoreboard;
        t_kind any_code  = 4'd0;
        t_kind none_code = 4'd1;
        bit    slot_used [ENTRIES];
        t_id   slot_type [ENTRIES];
        t_id   slot_name [ENTRIES];
        t_kind slot_kind [ENTRIES];
        t_res  due_results [$];
        int    errors;
        int    results_seen;

        function void set_codes(t_kind any_c, t_kind none_c);
            any_code  = any_c;
            none_code = none_c;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // merge one accepted item into the shadow table and queue its result
        function void merge_item(t_op op, t_id ty, t_id nm, t_kind kind);
            int   hit;
            int   free_slot;
            t_res r;
            hit       = -1;
            free_slot = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (hit < 0 && slot_used[i] && slot_type[i] == ty && slot_name[i] == nm)
                    hit = i;
                if (free_slot < 0 && !slot_used[i])
                    free_slot = i;
            end
            r.kind   = '0;
            r.status = ST_OK;
            if (op == OP_LOOKUP) begin
                r.kind = (hit >= 0) ? slot_kind[hit] : any_code;
            end else if (hit >= 0) begin
                // equal kind or an entry already at any stays as it is
                if (slot_kind[hit] != kind && slot_kind[hit] != any_code) begin
                    if (slot_kind[hit] == none_code) begin
                        slot_kind[hit] = kind;
                    end else begin
                        slot_kind[hit] = any_code;
                        r.status       = ST_CONFLICT;
                    end
                end
            end else if (free_slot >= 0) begin
                slot_used[free_slot] = 1'b1;
                slot_type[free_slot] = ty;
                slot_name[free_slot] = nm;
                slot_kind[free_slot] = kind;
            end else begin
                r.status = ST_FULL;
            end
            due_results.push_back(r);
        endfunction

        function void check_result(logic [KIND_W-1:0] got_kind, logic [1:0] got_status);
            t_res want;
            results_seen++;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: nothing pending, got kind %h status %0d",
                             results_seen, got_kind, got_status);
                return;
            end
            want = due_results.pop_front();
            if (got_kind !== want.kind || got_status !== want.status) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: kind exp %h got %h, status exp %0d got %0d",
                             results_seen, want.kind, got_kind, want.status, got_status);
            end
        endfunction

        function void close_out();
            if (due_results.size() != 0) begin
                errors++;
                $display("%0d items never answered", due_results.size());
            end
        endfunction
    endclass

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              i_opcode     = 1'b0;
    logic [ID_W-1:0]   i_type_id    = '0;
    logic [ID_W-1:0]   i_name_id    = '0;
    logic [KIND_W-1:0] i_value_kind = '0;
    logic              i_out_stall  = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [2:0]        paddr        = '0;
    logic [31:0]       pwdata       = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [KIND_W-1:0] o_result_kind;
    logic [1:0]        o_status;
    logic [31:0]       prdata;
    logic              pready;

    kind_table_scoreboard sb = new();

    t_id pool_type [KEY_POOL];
    t_id pool_name [KEY_POOL];
    int  burst_left = 0;
    int  stall_left = 0;
    int  stall_mode = 0;

    attribute_kind_merge_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_type_id     (i_type_id),
        .i_name_id     (i_name_id),
        .i_value_kind  (i_value_kind),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_kind (o_result_kind),
        .o_status      (o_status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    // receiver stall pattern: free-flowing, light, heavy or periodic stretches
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_left % 8 < 3);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.merge_item(t_op'(i_opcode), i_type_id, i_name_id, i_value_kind);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_result_kind, o_status);
    end

    task automatic send_item(input t_op op, input t_id ty, input t_id nm, input t_kind kind);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_type_id    <= ty;
        i_name_id    <= nm;
        i_value_kind <= kind;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    // hold the input off until every pending result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_codes(input t_kind any_c, input t_kind none_c);
        for (int r = 0; r < 2; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= (r == 0) ? ADDR_ANY_CODE : ADDR_NONE_CODE;
            // upper bits are junk, only the low nibble is a code
            pwdata  <= {28'($urandom_range(0, 32'h0fff_ffff)), (r == 0) ? any_c : none_c};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (pready !== 1'b1);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_codes(any_c, none_c);
    endtask

    function automatic t_kind pick_kind();
        case ($urandom_range(0, 7))
            0: return sb.any_code;
            1, 2: return sb.none_code;
            3, 4: return t_kind'($urandom_range(2, 3));
            default: return t_kind'($urandom_range(0, 15));
        endcase
    endfunction

    initial begin
        t_kind any_list  [PHASES];
        t_kind none_list [PHASES];
        t_id   ones;
        t_id   ty;
        t_id   nm;
        t_op   op;
        t_kind kind;
        int    pick;

        any_list  = '{4'd0, 4'd15, 4'd0,  4'd9, 4'd15, 4'd6};
        none_list = '{4'd1, 4'd0,  4'd15, 4'd9, 4'd15, 4'd11};
        ones      = '1;

        // pool keys share a type or a name with a neighbor now and then
        for (int i = 0; i < KEY_POOL; i++) begin
            pool_type[i] = (i % 3 == 1) ? pool_type[i-1] : {$urandom, $urandom};
            pool_name[i] = (i % 5 == 2) ? pool_name[i-1] : {$urandom, $urandom};
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_codes(4'd0, 4'd1);

        // absent lookup, insert, same kind, conflict, sticky any
        send_item(OP_LOOKUP, '0, '0, 4'd0);
        send_item(OP_STORE,  '0, '0, 4'd5);
        send_item(OP_LOOKUP, '0, '0, 4'd0);
        send_item(OP_STORE,  '0, '0, 4'd5);
        send_item(OP_STORE,  '0, '0, 4'd6);
        send_item(OP_LOOKUP, '0, '0, 4'd0);
        send_item(OP_STORE,  '0, '0, 4'd9);
        // none is replaced; lookup ignores value_kind
        send_item(OP_STORE,  ones, ones, 4'd1);
        send_item(OP_STORE,  ones, ones, 4'd15);
        send_item(OP_LOOKUP, ones, ones, 4'd15);
        // storing the any code over a concrete kind is a conflict
        send_item(OP_STORE,  ones, '0, 4'd7);
        send_item(OP_STORE,  ones, '0, 4'd0);
        send_item(OP_LOOKUP, ones, '0, 4'd3);
        send_item(OP_STORE,  '0, ones, 4'd1);
        send_item(OP_STORE,  '0, ones, 4'd1);
        send_item(OP_LOOKUP, '0, ones, 4'd0);
        send_item(OP_STORE,  64'ha5a5_a5a5_a5a5_a5a5, 64'h5a5a_5a5a_5a5a_5a5a, 4'd15);
        send_item(OP_LOOKUP, 64'ha5a5_a5a5_a5a5_a5a5, 64'h5a5a_5a5a_5a5a_5a5a, 4'd0);
        drain();

        // any and none share one code: such an entry never changes
        set_codes(4'd7, 4'd7);
        send_item(OP_STORE,  64'h1, 64'h2, 4'd7);
        send_item(OP_STORE,  64'h1, 64'h2, 4'd3);
        send_item(OP_LOOKUP, 64'h1, 64'h2, 4'd0);
        send_item(OP_LOOKUP, 64'h3, 64'h4, 4'd0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            set_codes(any_list[p], none_list[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(0, 1) == 0) ? OP_STORE : OP_LOOKUP;
                if ($urandom_range(0, 9) < 8) begin
                    pick = $urandom_range(0, KEY_POOL - 1);
                    ty   = pool_type[pick];
                    nm   = pool_name[pick];
                end else begin
                    ty = {$urandom, $urandom};
                    nm = {$urandom, $urandom};
                end
                kind = (op == OP_STORE) ? pick_kind() : t_kind'($urandom_range(0, 15));
                send_item(op, ty, nm, kind);
            end
            drain();
        end

        repeat (2 * ENTRIES + 4) @(posedge i_clk);
        sb.close_out();
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
